FILE: rtl/sfp_pkg.sv
package sfp_pkg;

    // Default frame store depth in bytes
    localparam int BUF_BYTES_DEF = 64;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Frame overhead around the payload: sync, sync, cmd, cmd, len, sum, end
    localparam int FRAME_OVERHEAD = 7;
    // Bytes after the last payload byte: sum and end marker
    localparam int TRAILER_BYTES  = 2;
    // Byte count slack used in the payload-done compare (count + 1 + trailer)
    localparam int DONE_SLACK     = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_FIRST   = 3'd0,
        REG_SYNC_SECOND  = 3'd1,
        REG_COMMAND_HIGH = 3'd2,
        REG_COMMAND_LOW  = 3'd3,
        REG_LENGTH_MIN   = 3'd4,
        REG_LENGTH_MAX   = 3'd5,
        REG_END_MARKER   = 3'd6
    } cfg_reg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr_en;        // write rx_byte into the frame store
        logic wr_zero;      // write at address zero instead of the byte count
        logic sum_clr;      // clear the running sum
        logic sum_add;      // add rx_byte to the running sum
        logic total_load;   // latch the frame length from rx_byte
        logic replay_start; // begin replaying the stored frame
    } sfp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sync1_hit;
        logic sync2_hit;
        logic cmdh_hit;
        logic cmdl_hit;
        logic len_ok;
        logic len_zero;
        logic data_done;
        logic sum_hit;
        logic end_hit;
        logic replay_busy;
    } sfp_status_t;

endpackage

FILE: rtl/sfp_ctrl.sv
module sfp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sfp_pkg::sfp_status_t status,
    output sfp_pkg::sfp_cmd_t    cmd
);
    import sfp_pkg::*;

    typedef enum logic [8:0] {
        ST_SYNC1  = 9'b000000001,
        ST_SYNC2  = 9'b000000010,
        ST_CMD0   = 9'b000000100,
        ST_CMD1   = 9'b000001000,
        ST_LEN    = 9'b000010000,
        ST_DATA   = 9'b000100000,
        ST_SUM    = 9'b001000000,
        ST_END    = 9'b010000000,
        ST_REPLAY = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    // Hold off input while the stored frame is being read out
    assign in_ready = (state_reg != ST_REPLAY);
    assign in_fire  = in_valid && in_ready;

    // Decode the next phase and the datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_SYNC1:
            begin
                if (in_fire)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_zero = 1'b1;
                    cmd.sum_clr = 1'b1;
                    if (status.sync1_hit)
                    begin
                        state_next = ST_SYNC2;
                    end
                end
            end
            ST_SYNC2:
            begin
                if (in_fire)
                begin
                    if (status.sync2_hit)
                    begin
                        cmd.wr_en  = 1'b1;
                        state_next = ST_CMD0;
                    end
                    else
                    begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_CMD0:
            begin
                if (in_fire)
                begin
                    if (status.cmdh_hit)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.sum_clr = 1'b1;
                        cmd.sum_add = 1'b1;
                        state_next  = ST_CMD1;
                    end
                    else
                    begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_CMD1:
            begin
                if (in_fire)
                begin
                    if (status.cmdl_hit)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.sum_add = 1'b1;
                        state_next  = ST_LEN;
                    end
                    else
                    begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_LEN:
            begin
                if (in_fire)
                begin
                    if (status.len_ok)
                    begin
                        cmd.wr_en      = 1'b1;
                        cmd.sum_add    = 1'b1;
                        cmd.total_load = 1'b1;
                        state_next     = status.len_zero ? ST_SUM : ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_DATA:
            begin
                if (in_fire)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.sum_add = 1'b1;
                    if (status.data_done)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (in_fire)
                begin
                    cmd.wr_en  = 1'b1;
                    state_next = status.sum_hit ? ST_END : ST_SYNC1;
                end
            end
            ST_END:
            begin
                if (in_fire)
                begin
                    cmd.wr_en = 1'b1;
                    if (status.end_hit)
                    begin
                        cmd.replay_start = 1'b1;
                        state_next       = ST_REPLAY;
                    end
                    else
                    begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_REPLAY:
            begin
                // Resume hunting once every stored byte has been read
                if (!status.replay_busy)
                begin
                    state_next = ST_SYNC1;
                end
            end
            default:
            begin
                state_next = ST_SYNC1;
            end
        endcase
    end

    // Advance the phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SYNC1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/sfp_datapath.sv
module sfp_datapath #(
    parameter int BUF_BYTES = sfp_pkg::BUF_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [sfp_pkg::BYTE_W-1:0]      rx_byte,
    input  sfp_pkg::sfp_cmd_t               cmd,
    output sfp_pkg::sfp_status_t            status,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [sfp_pkg::BYTE_W-1:0]      frame_byte,
    output logic [sfp_pkg::POS_W-1:0]       byte_position,
    output logic                            last
);
    import sfp_pkg::*;

    localparam int AW  = $clog2(BUF_BYTES);
    localparam int TW  = $clog2(BUF_BYTES + 1);
    localparam int TW1 = TW + 1;
    localparam logic [BYTE_W-1:0] LEN_LIMIT = BYTE_W'(BUF_BYTES - FRAME_OVERHEAD);

    // Configuration registers
    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [BYTE_W-1:0] command_high_reg;
    logic [BYTE_W-1:0] command_low_reg;
    logic [LEN_W-1:0]  length_min_reg;
    logic [LEN_W-1:0]  length_max_reg;
    logic [BYTE_W-1:0] end_marker_reg;

    // Frame assembly state
    logic [AW-1:0]     count_reg;
    logic [AW-1:0]     count_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [TW-1:0]     total_reg;
    logic [AW-1:0]     wr_addr;

    // Replay state
    logic              rd_active_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic              rd_en;
    logic              rd_last;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] frame_byte_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              last_reg;

    logic [BYTE_W-1:0] frame_mem [BUF_BYTES];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg   <= 8'd170;
            sync_second_reg  <= 8'd85;
            command_high_reg <= 8'd0;
            command_low_reg  <= 8'd130;
            length_min_reg   <= 6'd3;
            length_max_reg   <= 6'd57;
            end_marker_reg   <= 8'd13;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SYNC_FIRST:   sync_first_reg   <= cfg_wdata;
                REG_SYNC_SECOND:  sync_second_reg  <= cfg_wdata;
                REG_COMMAND_HIGH: command_high_reg <= cfg_wdata;
                REG_COMMAND_LOW:  command_low_reg  <= cfg_wdata;
                REG_LENGTH_MIN:   length_min_reg   <= cfg_wdata[LEN_W-1:0];
                REG_LENGTH_MAX:   length_max_reg   <= cfg_wdata[LEN_W-1:0];
                REG_END_MARKER:   end_marker_reg   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Compare the incoming byte against the expected header and trailer
    always_comb
    begin
        status.sync1_hit   = (rx_byte == sync_first_reg);
        status.sync2_hit   = (rx_byte == sync_second_reg);
        status.cmdh_hit    = (rx_byte == command_high_reg);
        status.cmdl_hit    = (rx_byte == command_low_reg);
        status.len_ok      = (rx_byte >= BYTE_W'(length_min_reg))
                          && (rx_byte <= BYTE_W'(length_max_reg))
                          && (rx_byte <= LEN_LIMIT);
        status.len_zero    = (rx_byte == '0);
        status.data_done   = (TW1'(count_reg) + TW1'(DONE_SLACK)) >= TW1'(total_reg);
        status.sum_hit     = (rx_byte == sum_reg);
        status.end_hit     = (rx_byte == end_marker_reg);
        status.replay_busy = rd_active_reg;
    end

    // Store address and running sum
    assign wr_addr    = cmd.wr_zero ? '0 : count_reg;
    assign count_next = wr_addr + AW'(1);
    assign sum_next   = (cmd.sum_clr ? '0 : sum_reg) + (cmd.sum_add ? rx_byte : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                count_reg <= count_next;
            end
            if (cmd.sum_clr || cmd.sum_add)
            begin
                sum_reg <= sum_next;
            end
            if (cmd.total_load)
            begin
                total_reg <= rx_byte[TW-1:0] + TW'(FRAME_OVERHEAD);
            end
        end
    end

    // Write the frame store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            frame_mem[wr_addr] <= rx_byte;
        end
    end

    // Read one stored byte whenever the output register is free
    assign rd_en   = rd_active_reg && (!out_valid_reg || out_ready);
    assign rd_last = (TW'(rd_idx_reg) + TW'(1)) == total_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rd_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_active_reg <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.replay_start)
            begin
                rd_active_reg <= 1'b1;
                rd_idx_reg    <= '0;
            end
            else if (rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
                if (rd_last)
                begin
                    rd_active_reg <= 1'b0;
                end
            end
        end
    end

    // Load the output register from the store
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            frame_byte_reg <= frame_mem[rd_idx_reg];
            pos_reg        <= POS_W'(rd_idx_reg);
            last_reg       <= rd_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_byte    = frame_byte_reg;
    assign byte_position = pos_reg;
    assign last          = last_reg;

endmodule

FILE: rtl/serial_frame_parser_with_sum_top.sv
// Serial frame parser with additive checksum.
// Input channel (in_valid/in_ready, rx_byte) takes one received byte per item.
// The parser hunts for two sync bytes, a two-byte command and a length byte
// inside [length_min, length_max]; it stores the payload, keeps an 8-bit
// wrapping sum from the first command byte through the payload, then checks
// the sum byte and the end marker.
// Output channel (out_valid/out_ready) carries frame_byte, byte_position and
// last. A good frame is replayed in full, length + 7 bytes, last set on the
// final one; a bad frame produces nothing.
// Throughput: one input byte per cycle while hunting and collecting. After the
// end marker the frame is read from the store at one byte per cycle while the
// receiver keeps taking them; input is held off until the last byte is read.
// Accepting the end marker sets the replay flag, and the first stored byte is
// then loaded into the output register. A stalled receiver holds the output
// register and pauses the store reads. Reset returns to hunting for the first
// sync byte and loads default register values. The user must write registers
// via cfg_wr_en/cfg_index/cfg_wdata only while the block idles (not enforced).
module serial_frame_parser_with_sum_top #(
    parameter int BUF_BYTES = sfp_pkg::BUF_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sfp_pkg::BYTE_W-1:0]      rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sfp_pkg::BYTE_W-1:0]      frame_byte,
    output logic [sfp_pkg::POS_W-1:0]       byte_position,
    output logic                            last
);
    import sfp_pkg::*;

    sfp_cmd_t    cmd;
    sfp_status_t status;

    sfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sfp_datapath #(
        .BUF_BYTES (BUF_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .rx_byte       (rx_byte),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .last          (last)
    );

endmodule

FILE: rtl/sfp_checker.sv
module sfp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [sfp_pkg::BYTE_W-1:0]      rx_byte,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [sfp_pkg::BYTE_W-1:0]      frame_byte,
    input logic [sfp_pkg::POS_W-1:0]       byte_position,
    input logic                            last
);
    import sfp_pkg::*;

    // A waiting input item holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(rx_byte))
        else $error("input item changed while waiting");

    // A stalled item holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte)
            && $stable(byte_position) && $stable(last))
        else $error("output item changed while stalled");

    // Inside a frame the next item follows at once with the next position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid
            && (byte_position == $past(byte_position) + POS_W'(1)))
        else $error("replay skipped or repeated a byte");

    // Every frame is at least header plus trailer long
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> byte_position >= POS_W'(FRAME_OVERHEAD - 1))
        else $error("frame ended too early");

    // A new frame starts at position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid || byte_position == '0)
        else $error("frame did not start at position zero");

endmodule

bind serial_frame_parser_with_sum_top sfp_checker u_sfp_checker (.*);

FILE: test/serial_frame_parser_with_sum_top_test.sv
`timescale 1ns / 1ps

module serial_frame_parser_with_sum_top_test;

    import sfp_pkg::*;

    localparam int BUF_BYTES    = BUF_BYTES_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_STALL   = 600;

    // Parser phases mirrored by the frame predictor
    typedef enum logic [2:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        HUNT_CMD0,
        HUNT_CMD1,
        HUNT_LEN,
        TAKE_DATA,
        TAKE_SUM,
        TAKE_END
    } hunt_phase_t;

    // Shapes of generated byte sequences
    typedef enum int {
        FK_GOOD,
        FK_BAD_SUM,
        FK_BAD_END,
        FK_BAD_HDR,
        FK_BAD_LEN,
        FK_NOISE
    } frame_kind_t;

    // Receiver ready behavior
    typedef enum int {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PATTERN
    } ready_mode_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              last;
    } replay_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SYNC_FIRST;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     rx_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [BYTE_W-1:0]     frame_byte;
    logic [POS_W-1:0]      byte_position;
    logic                  last;

    // Register copies used by the predictor and the frame builder
    logic [7:0] cfg_sync1;
    logic [7:0] cfg_sync2;
    logic [7:0] cfg_cmd_h;
    logic [7:0] cfg_cmd_l;
    logic [5:0] cfg_len_min;
    logic [5:0] cfg_len_max;
    logic [7:0] cfg_end;

    // Predictor state
    hunt_phase_t hunt_phase = HUNT_SYNC1;
    logic [5:0]  byte_cnt   = '0;
    logic [7:0]  run_sum    = '0;
    logic [6:0]  frame_tot  = '0;
    logic [7:0]  frame_mem [BUF_BYTES];

    logic [7:0]   rx_pending [$];
    replay_byte_t frame_replay_q [$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          items_queued   = 0;
    int          gap_max        = 0;
    int          gap_left       = 0;
    int          burst_left     = 1;
    ready_mode_t ready_mode     = RDY_ALWAYS;
    int          stall_req      = 0;
    int          stall_seen     = 0;
    int          stall_left     = 0;
    int          rx_cycle       = 0;

    serial_frame_parser_with_sum_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the frame predictor by one accepted byte
    task automatic parse_rx_byte(input logic [7:0] b);
        replay_byte_t e;
        int           total;
        case (hunt_phase)
            HUNT_SYNC1:
            begin
                byte_cnt = '0;
                run_sum = '0;
                frame_mem[0] = b;
                if (b == cfg_sync1)
                begin
                    byte_cnt = 6'd1;
                    hunt_phase = HUNT_SYNC2;
                end
            end
            HUNT_SYNC2:
            begin
                if (b == cfg_sync2)
                begin
                    frame_mem[1] = b;
                    byte_cnt = 6'd2;
                    hunt_phase = HUNT_CMD0;
                end
                else
                    hunt_phase = HUNT_SYNC1;
            end
            HUNT_CMD0:
            begin
                if (b == cfg_cmd_h)
                begin
                    frame_mem[2] = b;
                    run_sum = b;
                    byte_cnt = 6'd3;
                    hunt_phase = HUNT_CMD1;
                end
                else
                    hunt_phase = HUNT_SYNC1;
            end
            HUNT_CMD1:
            begin
                if (b == cfg_cmd_l)
                begin
                    frame_mem[3] = b;
                    run_sum = run_sum + b;
                    byte_cnt = 6'd4;
                    hunt_phase = HUNT_LEN;
                end
                else
                    hunt_phase = HUNT_SYNC1;
            end
            HUNT_LEN:
            begin
                // Reject out-of-range lengths and frames that overflow the store
                if (int'(b) < int'(cfg_len_min) || int'(b) > int'(cfg_len_max) ||
                    int'(b) + FRAME_OVERHEAD > BUF_BYTES)
                    hunt_phase = HUNT_SYNC1;
                else
                begin
                    frame_mem[4] = b;
                    run_sum = run_sum + b;
                    frame_tot = 7'(int'(b) + FRAME_OVERHEAD);
                    byte_cnt = 6'd5;
                    hunt_phase = (b == 8'd0) ? TAKE_SUM : TAKE_DATA;
                end
            end
            TAKE_DATA:
            begin
                frame_mem[byte_cnt] = b;
                run_sum = run_sum + b;
                byte_cnt = byte_cnt + 6'd1;
                if (int'(byte_cnt) + TRAILER_BYTES >= int'(frame_tot))
                    hunt_phase = TAKE_SUM;
            end
            TAKE_SUM:
            begin
                frame_mem[byte_cnt] = b;
                byte_cnt = byte_cnt + 6'd1;
                hunt_phase = (b == run_sum) ? TAKE_END : HUNT_SYNC1;
            end
            default:
            begin
                frame_mem[byte_cnt] = b;
                // Replay the whole stored frame on a matching end marker
                if (b == cfg_end)
                begin
                    total = (int'(frame_tot) > BUF_BYTES) ? BUF_BYTES : int'(frame_tot);
                    for (int i = 0; i < total; i++)
                    begin
                        e.data = frame_mem[i];
                        e.pos  = POS_W'(i);
                        e.last = (i + 1 == total);
                        frame_replay_q.push_back(e);
                    end
                end
                hunt_phase = HUNT_SYNC1;
            end
        endcase
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            REG_SYNC_FIRST:   cfg_sync1 = v;
            REG_SYNC_SECOND:  cfg_sync2 = v;
            REG_COMMAND_HIGH: cfg_cmd_h = v;
            REG_COMMAND_LOW:  cfg_cmd_l = v;
            REG_LENGTH_MIN:   cfg_len_min = v[5:0];
            REG_LENGTH_MAX:   cfg_len_max = v[5:0];
            default:          cfg_end = v;
        endcase
    endtask

    task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] ch, input logic [7:0] cl,
                              input logic [7:0] mn, input logic [7:0] mx,
                              input logic [7:0] em);
        write_reg(REG_SYNC_FIRST, s1);
        write_reg(REG_SYNC_SECOND, s2);
        write_reg(REG_COMMAND_HIGH, ch);
        write_reg(REG_COMMAND_LOW, cl);
        write_reg(REG_LENGTH_MIN, mn);
        write_reg(REG_LENGTH_MAX, mx);
        write_reg(REG_END_MARKER, em);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until all bytes are in and every expected frame byte has come out
    task automatic wait_idle();
        do
            @(posedge clk);
        while (rx_pending.size() != 0 || in_valid || frame_replay_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Favor short payloads, reach the full range now and then
    function automatic int pick_length();
        int hi;
        if (cfg_len_min > cfg_len_max)
            return $urandom_range(0, 10);
        hi = int'(cfg_len_max);
        if ($urandom_range(0, 4) != 0 && int'(cfg_len_min) + 6 < hi)
            hi = int'(cfg_len_min) + 6;
        return $urandom_range(int'(cfg_len_min), hi);
    endfunction

    // Build a frame from the current registers and corrupt it as asked
    task automatic queue_frame(input frame_kind_t kind, input int len);
        logic [7:0] bytes [$];
        logic [7:0] sum;
        logic [7:0] v;
        int         pos;
        if (kind == FK_NOISE)
        begin
            repeat ($urandom_range(1, 8))
            begin
                v = ($urandom_range(0, 3) == 0) ? cfg_sync1 : 8'($urandom);
                rx_pending.push_back(v);
                items_queued++;
            end
            return;
        end
        bytes.push_back(cfg_sync1);
        bytes.push_back(cfg_sync2);
        bytes.push_back(cfg_cmd_h);
        bytes.push_back(cfg_cmd_l);
        bytes.push_back(8'(len));
        sum = cfg_cmd_h + cfg_cmd_l + 8'(len);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0:       v = 8'h00;
                1:       v = 8'hFF;
                default: v = 8'($urandom);
            endcase
            bytes.push_back(v);
            sum = sum + v;
        end
        bytes.push_back(sum);
        bytes.push_back(cfg_end);
        case (kind)
            FK_BAD_SUM:
                bytes[len + 5] = sum ^ 8'($urandom_range(1, 255));
            FK_BAD_END:
                bytes[len + 6] = cfg_end ^ 8'($urandom_range(1, 255));
            FK_BAD_HDR:
            begin
                pos = $urandom_range(0, 3);
                bytes[pos] = bytes[pos] ^ 8'($urandom_range(1, 255));
            end
            FK_BAD_LEN:
            begin
                pos = $urandom_range(0, 2);
                if (pos == 0 && cfg_len_min > 0)
                    bytes[4] = 8'($urandom_range(0, int'(cfg_len_min) - 1));
                else if (pos == 1)
                    bytes[4] = 8'($urandom_range(int'(cfg_len_max) + 1, 255));
                else
                    bytes[4] = 8'($urandom_range(BUF_BYTES - FRAME_OVERHEAD + 1, 255));
            end
            default: ;
        endcase
        foreach (bytes[i])
            rx_pending.push_back(bytes[i]);
        items_queued += bytes.size();
    endtask

    // Mostly well-formed frames, the rest broken frames and line noise
    task automatic run_random_phase(input int target);
        int          start;
        int          pick;
        frame_kind_t kind;
        start = items_queued;
        while (items_queued - start < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                kind = FK_GOOD;
            else if (pick < 65)
                kind = FK_BAD_SUM;
            else if (pick < 75)
                kind = FK_BAD_END;
            else if (pick < 85)
                kind = FK_BAD_HDR;
            else if (pick < 93)
                kind = FK_BAD_LEN;
            else
                kind = FK_NOISE;
            queue_frame(kind, pick_length());
        end
    endtask

    // Drive rx bytes in bursts, predict each accepted byte
    always @(posedge clk)
    begin : drive_rx
        logic       nv;
        logic [7:0] nb;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                parse_rx_byte(rx_byte);
            if (!in_valid || in_ready)
            begin
                nv = 1'b0;
                nb = rx_byte;
                if (gap_left > 0)
                    gap_left--;
                else if (rx_pending.size() > 0)
                begin
                    nv = 1'b1;
                    nb = rx_pending.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        if (gap_max == 0 || $urandom_range(0, 2) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, gap_max);
                    end
                end
                in_valid <= nv;
                rx_byte <= nb;
            end
        end
    end

    // Check replayed frame bytes and pace out_ready
    always @(posedge clk)
    begin : watch_frames
        replay_byte_t exp_b;
        logic         nr;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (frame_replay_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: frame_byte: expected none, actual %02h pos %0d last %0b",
                             $time, frame_byte, byte_position, last);
                end
                else
                begin
                    exp_b = frame_replay_q.pop_front();
                    if (frame_byte !== exp_b.data)
                    begin
                        mismatch_count++;
                        $display("%0t: frame_byte: expected %02h, actual %02h",
                                 $time, exp_b.data, frame_byte);
                    end
                    if (byte_position !== exp_b.pos)
                    begin
                        mismatch_count++;
                        $display("%0t: byte_position: expected %0d, actual %0d",
                                 $time, exp_b.pos, byte_position);
                    end
                    if (last !== exp_b.last)
                    begin
                        mismatch_count++;
                        $display("%0t: last: expected %0b, actual %0b",
                                 $time, exp_b.last, last);
                    end
                end
            end
            // Long hold-off on request, otherwise the current ready mode
            if (stall_req != stall_seen)
            begin
                stall_seen = stall_req;
                stall_left = LONG_STALL;
                nr = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nr = 1'b0;
            end
            else
            begin
                case (ready_mode)
                    RDY_RANDOM:  nr = ($urandom_range(0, 9) < 7);
                    RDY_PATTERN: nr = ((rx_cycle % 7) >= 3);
                    default:     nr = 1'b1;
                endcase
            end
            rx_cycle++;
            out_ready <= nr;
        end
    end

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] s1;
        logic [7:0] mn;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: byte extremes, a good frame, a broken sync pair
        ready_mode = RDY_ALWAYS;
        gap_max = 0;
        set_config(8'd170, 8'd85, 8'd0, 8'd130, 8'd3, 8'd57, 8'd13);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        queue_frame(FK_GOOD, 3);
        // second sync byte replaced by a first sync: not rechecked
        rx_pending.push_back(cfg_sync1);
        rx_pending.push_back(cfg_sync1);
        rx_pending.push_back(cfg_sync2);
        wait_idle();

        // Directed: fixed zero-length frames, good and with a bad end marker, then a length-one frame outside the range
        set_config(8'h00, 8'hFF, 8'hFF, 8'h00, 8'd0, 8'd0, 8'hFF);
        queue_frame(FK_GOOD, 0);
        queue_frame(FK_BAD_END, 0);
        queue_frame(FK_GOOD, 1);
        wait_idle();

        // Default registers, largest frame first
        ready_mode = RDY_RANDOM;
        gap_max = 6;
        set_config(8'd170, 8'd85, 8'd0, 8'd130, 8'd3, 8'd57, 8'd13);
        queue_frame(FK_GOOD, 57);
        run_random_phase(40);
        wait_idle();

        // Extreme registers; receiver holds off while the sender streams
        ready_mode = RDY_PATTERN;
        gap_max = 0;
        set_config(8'hFF, 8'h00, 8'hFF, 8'h00, 8'd0, 8'd57, 8'h00);
        stall_req++;
        queue_frame(FK_GOOD, 2);
        queue_frame(FK_GOOD, 5);
        run_random_phase(45);
        wait_idle();

        // Fixed-length frames with random header bytes
        ready_mode = RDY_RANDOM;
        gap_max = 10;
        mn = 8'($urandom_range(1, 6));
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), mn, mn,
                   8'($urandom));
        run_random_phase(30);
        wait_idle();

        // Empty length range: nothing gets through
        ready_mode = RDY_ALWAYS;
        gap_max = 4;
        set_config(8'd170, 8'd85, 8'd0, 8'd130, 8'd40, 8'd2, 8'd13);
        run_random_phase(20);
        wait_idle();

        // Random registers, sometimes both sync bytes equal
        ready_mode = RDY_ALWAYS;
        gap_max = 3;
        s1 = 8'($urandom);
        mn = 8'($urandom_range(0, 5));
        set_config(s1, ($urandom_range(0, 1) == 0) ? s1 : 8'($urandom), 8'($urandom),
                   8'($urandom), mn, mn + 8'($urandom_range(0, 10)), 8'($urandom));
        run_random_phase(35);
        wait_idle();

        if (mismatch_count == 0 && frame_replay_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
